// ===== rtl/cafc_pkg.sv =====
// ----------------------------------------------------------------------------
// cafc_pkg
// Shared types and constants of the curve archive frame checker.
// ----------------------------------------------------------------------------
package cafc_pkg;

  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned RECORD_BYTES = 20;
  localparam int unsigned CRC_FIELD_LO = 24;
  localparam int unsigned CRC_FIELD_HI = 28;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [14:0] POSITION_MAX = 15'h7FFF;
  localparam logic [10:0] COUNTER_MAX  = 11'h7FF;
  localparam logic [15:0] VERSION_RESET = 16'd1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SIZE        = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_BAD_HEADER  = 3'd5,
    ST_BAD_WRAP    = 3'd6,
    ST_BAD_CRC     = 3'd7
  } status_t;

  // one byte handed to the frame core
  typedef struct packed {
    logic       go;
    logic [7:0] data;
    logic       last;
  } step_t;

  // one finished frame result
  typedef struct packed {
    status_t     status;
    logic [14:0] needed_length;
    logic [9:0]  bad_record_index;
    logic [10:0] keys_in_frame;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h41;  // A
      3'd1: b = 8'h43;  // C
      3'd2: b = 8'h53;  // S
      3'd3: b = 8'h43;  // C
      3'd4: b = 8'h55;  // U
      3'd5: b = 8'h52;  // R
      3'd6: b = 8'h56;  // V
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/curve_archive_frame_checker.sv =====
// ----------------------------------------------------------------------------
// curve_archive_frame_checker
// Streams an archive frame byte by byte and reports one status per frame.
// ----------------------------------------------------------------------------
// channel  | direction | payload                                    | handshake
// input    | in        | data_byte, frame_last                      | in_valid / in_stall
// result   | out       | status, needed_length, bad_record_index,   | out_valid / out_stall
//          |           | keys_in_frame                              |
// config   | in        | cfg_wdata (expected version)               | cfg_we
//
// one byte per cycle unless stalled; the result is registered as the final byte is consumed
// the byte register feeds the crc byte update and field capture in the same cycle
// a final byte and the bytes behind it wait while a result is stalled; others keep flowing
// rst is synchronous and clears the frame state and both valid flags; version resets to 1
// ----------------------------------------------------------------------------
module curve_archive_frame_checker import cafc_pkg::*; #(
  parameter int unsigned MAX_KEYS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [14:0] needed_length,
  output logic [9:0]  bad_record_index,
  output logic [10:0] keys_in_frame
);

  logic [15:0] expected_version;
  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  logic        a_go;
  logic        in_take;
  step_t       step;
  result_t     res;
  result_t     out_reg;

  // a final byte needs room in the result register
  assign a_go     = a_valid && (!a_last || !out_valid || !out_stall);
  assign in_stall = a_valid && !a_go;
  assign in_take  = in_valid && !in_stall;

  assign step.go   = a_go;
  assign step.data = a_byte;
  assign step.last = a_last;

  cafc_frame_core #(.MAX_KEYS(MAX_KEYS)) u_core (
    .clk              (clk),
    .rst              (rst),
    .expected_version (expected_version),
    .step             (step),
    .result           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (cfg_we) begin
      expected_version <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
    if (in_take) begin
      a_byte <= data_byte;
      a_last <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go && a_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (a_go && a_last) out_reg <= res;
  end

  assign status           = out_reg.status;
  assign needed_length    = out_reg.needed_length;
  assign bad_record_index = out_reg.bad_record_index;
  assign keys_in_frame    = out_reg.keys_in_frame;

endmodule

// ===== rtl/cafc_crc8.sv =====
// ----------------------------------------------------------------------------
// cafc_crc8
// Reflected CRC-32 update by one byte.
// ----------------------------------------------------------------------------
module cafc_crc8 import cafc_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

// ===== rtl/cafc_frame_core.sv =====
// ----------------------------------------------------------------------------
// cafc_frame_core
// Per-frame state: crc, header capture, record watch and final status.
// ----------------------------------------------------------------------------
module cafc_frame_core import cafc_pkg::*; #(
  parameter int unsigned MAX_KEYS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] expected_version,
  input  step_t       step,
  output result_t     result
);

  localparam logic [31:0] MaxKeys = 32'(MAX_KEYS);
  localparam logic [31:0] MaxLen  = 32'(HEADER_BYTES + RECORD_BYTES * MAX_KEYS);

  logic [31:0] running_crc;
  logic [14:0] byte_position;
  status_t     first_header_fault;
  logic [31:0] header_key_count;
  logic [31:0] header_payload_length;
  logic [7:0]  wrap_before;
  logic [7:0]  wrap_after;
  logic [31:0] stored_crc;
  logic [4:0]  record_byte_offset;
  logic [10:0] record_counter;
  logic        reserved_fault_seen;
  logic [9:0]  reserved_fault_record;

  logic [31:0] running_crc_next;
  status_t     fault_code;
  status_t     first_header_fault_next;
  logic        reserved_fault_seen_next;
  logic [9:0]  reserved_fault_record_next;
  logic        in_header;
  logic [4:0]  hdr_idx;
  logic [7:0]  fed;
  logic [4:0]  offset_inc;

  assign in_header = byte_position < 15'(HEADER_BYTES);
  assign hdr_idx   = byte_position[4:0];
  assign fed = (byte_position >= 15'(CRC_FIELD_LO) && byte_position < 15'(CRC_FIELD_HI)) ?
               8'd0 : step.data;
  assign offset_inc = record_byte_offset + 5'd1;

  cafc_crc8 u_crc (
    .crc_in  (running_crc),
    .data    (fed),
    .crc_out (running_crc_next)
  );

  // header byte checks
  always_comb begin
    fault_code = ST_OK;
    if (hdr_idx < 5'd8) begin
      if (step.data != magic_byte(hdr_idx[2:0])) fault_code = ST_BAD_MAGIC;
    end else if (hdr_idx == 5'd8) begin
      if (step.data != expected_version[7:0]) fault_code = ST_BAD_VERSION;
    end else if (hdr_idx == 5'd9) begin
      if (step.data != expected_version[15:8]) fault_code = ST_BAD_VERSION;
    end else if (hdr_idx == 5'd10) begin
      if (step.data != 8'(HEADER_BYTES)) fault_code = ST_BAD_HEADER;
    end else if (hdr_idx == 5'd11 || hdr_idx == 5'd18 || hdr_idx == 5'd19 ||
                 hdr_idx >= 5'd28) begin
      if (step.data != 8'd0) fault_code = ST_BAD_HEADER;
    end
  end

  always_comb begin
    first_header_fault_next = first_header_fault;
    if (in_header && first_header_fault == ST_OK) first_header_fault_next = fault_code;
    reserved_fault_seen_next   = reserved_fault_seen;
    reserved_fault_record_next = reserved_fault_record;
    if (!in_header && record_byte_offset >= 5'd18 && step.data != 8'd0 &&
        !reserved_fault_seen) begin
      reserved_fault_seen_next   = 1'b1;
      reserved_fault_record_next = record_counter[9:0];
    end
  end

  // final decision
  logic [15:0] frame_len;
  logic [16:0] kc_lo;
  logic [20:0] rec_bytes;
  logic [20:0] req_len;

  assign frame_len = {1'b0, byte_position} + 16'd1;
  assign kc_lo     = header_key_count[16:0];
  assign rec_bytes = {kc_lo, 4'b0} + {2'b0, kc_lo, 2'b0};
  assign req_len   = rec_bytes + 21'(HEADER_BYTES);

  always_comb begin
    result.status           = ST_OK;
    result.needed_length    = 15'd0;
    result.bad_record_index = 10'd0;
    result.keys_in_frame    = 11'd0;
    priority if (frame_len < 16'(HEADER_BYTES)) begin
      result.status        = ST_SIZE;
      result.needed_length = 15'(HEADER_BYTES);
    end else if ({16'd0, frame_len} > MaxLen) begin
      result.status        = ST_TOO_MANY;
      result.needed_length = MaxLen[14:0];
    end else if (first_header_fault_next != ST_OK) begin
      result.status = first_header_fault_next;
    end else if (header_key_count > MaxKeys) begin
      result.status        = ST_TOO_MANY;
      result.needed_length = MaxLen[14:0];
    end else begin
      result.needed_length = req_len[14:0];
      priority if (header_payload_length != {11'd0, rec_bytes} ||
                   {5'd0, frame_len} != req_len) begin
        result.status = ST_SIZE;
      end else if (wrap_before > 8'd2 || wrap_after > 8'd2) begin
        result.status = ST_BAD_WRAP;
      end else if (~running_crc_next != stored_crc) begin
        result.status = ST_BAD_CRC;
      end else if (reserved_fault_seen_next) begin
        result.status           = ST_BAD_HEADER;
        result.bad_record_index = reserved_fault_record_next;
      end else begin
        result.keys_in_frame = header_key_count[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step.go && step.last)) begin
      running_crc           <= CRC_INIT;
      byte_position         <= 15'd0;
      first_header_fault    <= ST_OK;
      header_key_count      <= 32'd0;
      header_payload_length <= 32'd0;
      wrap_before           <= 8'd0;
      wrap_after            <= 8'd0;
      stored_crc            <= 32'd0;
      record_byte_offset    <= 5'd0;
      record_counter        <= 11'd0;
      reserved_fault_seen   <= 1'b0;
      reserved_fault_record <= 10'd0;
    end else if (step.go) begin
      running_crc           <= running_crc_next;
      first_header_fault    <= first_header_fault_next;
      reserved_fault_seen   <= reserved_fault_seen_next;
      reserved_fault_record <= reserved_fault_record_next;
      if (byte_position < POSITION_MAX) byte_position <= byte_position + 15'd1;
      if (in_header) begin
        // little-endian byte lanes of the multi-byte fields
        if (hdr_idx >= 5'd12 && hdr_idx < 5'd16)
          header_key_count[{hdr_idx[1:0], 3'b000} +: 8] <= step.data;
        if (hdr_idx == 5'd16) wrap_before <= step.data;
        if (hdr_idx == 5'd17) wrap_after <= step.data;
        if (hdr_idx >= 5'd20 && hdr_idx < 5'd24)
          header_payload_length[{hdr_idx[1:0], 3'b000} +: 8] <= step.data;
        if (hdr_idx >= 5'd24 && hdr_idx < 5'd28)
          stored_crc[{hdr_idx[1:0], 3'b000} +: 8] <= step.data;
      end else begin
        if (offset_inc >= 5'(RECORD_BYTES)) begin
          record_byte_offset <= 5'd0;
          if (record_counter < COUNTER_MAX) record_counter <= record_counter + 11'd1;
        end else begin
          record_byte_offset <= offset_inc;
        end
      end
    end
  end

endmodule

// ===== rtl/cafc_checker.sv =====
// ----------------------------------------------------------------------------
// cafc_checker
// Port-level checks of the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module cafc_checker import cafc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [14:0] needed_length,
  input logic [9:0]  bad_record_index,
  input logic [10:0] keys_in_frame
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(needed_length) &&
      $stable(bad_record_index) && $stable(keys_in_frame))
    else $error("result changed while stalled");

  a_keys_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> keys_in_frame == 11'd0)
    else $error("key count on a failed frame");

  a_record_only_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BAD_HEADER |-> bad_record_index == 10'd0)
    else $error("record index without a record fault");

  a_no_len_on_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD_MAGIC || status == ST_BAD_VERSION) |->
      needed_length == 15'd0)
    else $error("length reported on a magic or version fault");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind curve_archive_frame_checker cafc_checker u_cafc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .status           (status),
  .needed_length    (needed_length),
  .bad_record_index (bad_record_index),
  .keys_in_frame    (keys_in_frame)
);
